FILE: rtl/srtf_tick_scheduler_core_assert.svh
// Assertion macros shared by the checker files of the scheduler.
`ifndef SRTF_TICK_SCHEDULER_CORE_ASSERT_SVH
`define SRTF_TICK_SCHEDULER_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SRTF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srtf scheduler assertion failed");

// Antecedent implies consequent in the next cycle.
`define SRTF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srtf scheduler assertion failed");

`endif

FILE: rtl/srtf_pkg.sv
package srtf_pkg;

    // Widths of the item fields.
    localparam int KIND_W  = 2;
    localparam int SLOT_IN_W = 4;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int OUT_W   = 16;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SLOT_IN_W-1:0] slot;
        logic [ARR_W-1:0]     arrival_time;
        logic [BURST_W-1:0]   burst_length;
    } s_item_t;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] running_slot;
        logic                 idle;
        logic                 job_finished;
        logic [OUT_W-1:0]     turnaround;
        logic [OUT_W-1:0]     job_waiting;
        logic [OUT_W-1:0]     current_time;
    } m_item_t;

endpackage

FILE: rtl/srtf_tick_scheduler_core.sv
// A tick item sweeps the slot memory at one entry per cycle, then finishes the tick in a
// final state; load, clear and other items go straight to the result hand-off.
// One item is handled at a time; the next item is accepted as soon as the result moves to
// the output register.
// Reset (aresetn, synchronous, active low) clears the time, the loaded and done flags and the
// handshake state; the slot memory is not cleared and needs no clearing pass.
module srtf_tick_scheduler_core #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  srtf_pkg::s_item_t s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output srtf_pkg::m_item_t m_item
);
    import srtf_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W = 2 * TIME_BITS + BURST_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FINAL = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Saturating increment of a time or wait count.
    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

    // Fit a time value into an output field.
    function automatic logic [OUT_W-1:0] to_out(input logic [TIME_BITS-1:0] v);
        logic [TIME_BITS+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    // Fit a slot index into the output slot field.
    function automatic logic [SLOT_IN_W-1:0] to_slot(input logic [SLOT_W-1:0] v);
        logic [SLOT_W+SLOT_IN_W-1:0] w;
        w = {{SLOT_IN_W{1'b0}}, v};
        return w[SLOT_IN_W-1:0];
    endfunction

    // Slot memory: each word holds arrival, remaining and waiting.
    logic [WORD_W-1:0] slot_mem [NUM_SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [SLOT_W-1:0] rd_addr;

    logic [1:0]           state_reg, state_next;
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic [NUM_SLOTS-1:0] loaded_reg, loaded_next;
    logic [NUM_SLOTS-1:0] done_reg, done_next;
    logic [SLOT_W-1:0]    iss_reg, iss_next;
    logic                 iss_on_reg, iss_on_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                 chk_on_reg, chk_on_next;
    logic                 found_reg, found_next;
    logic [SLOT_W-1:0]    best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] best_arr_reg, best_arr_next;
    logic [BURST_W-1:0]   best_rem_reg, best_rem_next;
    logic [TIME_BITS-1:0] best_wait_reg, best_wait_next;
    m_item_t              res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    m_item_t              m_item_reg, m_item_next;

    // Load decode: slot range check and arrival clamp.
    logic [SLOT_W+SLOT_IN_W-1:0] slot_wide;
    logic                        slot_in_range;
    logic [SLOT_W-1:0]           slot_idx;
    logic [TIME_BITS+ARR_W-1:0]  arr_wide;
    logic [TIME_BITS+ARR_W-1:0]  time_max_wide;
    logic [TIME_BITS-1:0]        arr_clamp;

    assign slot_wide     = {{SLOT_W{1'b0}}, s_item.slot};
    assign slot_in_range = slot_wide < (SLOT_W + SLOT_IN_W)'(NUM_SLOTS);
    assign slot_idx      = slot_wide[SLOT_W-1:0];
    assign arr_wide      = {{TIME_BITS{1'b0}}, s_item.arrival_time};
    assign time_max_wide = {{ARR_W{1'b0}}, TIME_MAX};
    assign arr_clamp     = (arr_wide > time_max_wide) ? TIME_MAX : arr_wide[TIME_BITS-1:0];

    // Fields of the entry under inspection during the sweep.
    logic [TIME_BITS-1:0] chk_arr;
    logic [BURST_W-1:0]   chk_rem;
    logic [TIME_BITS-1:0] chk_wait;
    logic                 chk_ready;
    logic                 chk_better;

    assign chk_arr   = rd_data_reg[WORD_W-1 -: TIME_BITS];
    assign chk_rem   = rd_data_reg[TIME_BITS +: BURST_W];
    assign chk_wait  = rd_data_reg[TIME_BITS-1:0];
    assign chk_ready = chk_on_reg && loaded_reg[chk_idx_reg] && !done_reg[chk_idx_reg]
                       && (chk_arr <= clock_reg);
    assign chk_better = !found_reg || (chk_rem < best_rem_reg)
                        || ((chk_rem == best_rem_reg) && (chk_arr < best_arr_reg));

    // Values for the end of a tick.
    logic [TIME_BITS-1:0] clock_inc;
    logic [BURST_W-1:0]   rem_dec;
    logic [TIME_BITS-1:0] tat;

    assign clock_inc = sat_inc(clock_reg);
    assign rem_dec   = best_rem_reg - 1'b1;
    assign tat       = clock_inc - best_arr_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Sequencer: decode an item, sweep the slots, finish the tick, hand off the result.
    always_comb begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        loaded_next    = loaded_reg;
        done_next      = done_reg;
        iss_next       = iss_reg;
        iss_on_next    = iss_on_reg;
        chk_idx_next   = chk_idx_reg;
        chk_on_next    = chk_on_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_arr_next  = best_arr_reg;
        best_rem_next  = best_rem_reg;
        best_wait_next = best_wait_reg;
        res_next       = res_reg;
        m_item_next    = m_item_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = '0;
        rd_addr        = iss_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next = '0;
                    unique case (s_item.kind)
                        KIND_LOAD: begin
                            if (slot_in_range) begin
                                wr_en   = 1'b1;
                                wr_addr = slot_idx;
                                wr_data = {arr_clamp, s_item.burst_length, {TIME_BITS{1'b0}}};
                                loaded_next[slot_idx] = 1'b1;
                                done_next[slot_idx]   = (s_item.burst_length == '0);
                            end
                            res_next.current_time = to_out(clock_reg);
                            state_next = ST_EMIT;
                        end
                        KIND_TICK: begin
                            iss_next    = '0;
                            iss_on_next = 1'b1;
                            found_next  = 1'b0;
                            state_next  = ST_SCAN;
                        end
                        KIND_CLEAR: begin
                            clock_next  = '0;
                            loaded_next = '0;
                            done_next   = '0;
                            state_next  = ST_EMIT;
                        end
                        default: begin
                            res_next.current_time = to_out(clock_reg);
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Read one entry per cycle; inspect the entry read in the previous cycle.
                chk_on_next  = iss_on_reg;
                chk_idx_next = iss_reg;
                if (iss_on_reg) begin
                    if (iss_reg == LAST_SLOT) begin
                        iss_on_next = 1'b0;
                    end else begin
                        iss_next = iss_reg + 1'b1;
                    end
                end
                // Every ready job gains a wait unit now; the chosen one is restored later.
                if (chk_ready) begin
                    wr_en   = 1'b1;
                    wr_addr = chk_idx_reg;
                    wr_data = {chk_arr, chk_rem, sat_inc(chk_wait)};
                    if (chk_better) begin
                        found_next     = 1'b1;
                        best_idx_next  = chk_idx_reg;
                        best_arr_next  = chk_arr;
                        best_rem_next  = chk_rem;
                        best_wait_next = chk_wait;
                    end
                end
                if (chk_on_reg && (chk_idx_reg == LAST_SLOT)) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                clock_next = clock_inc;
                res_next   = '0;
                res_next.current_time = to_out(clock_inc);
                if (found_reg) begin
                    // The running job keeps its old wait count and loses one unit of work.
                    wr_en   = 1'b1;
                    wr_addr = best_idx_reg;
                    wr_data = {best_arr_reg, rem_dec, best_wait_reg};
                    res_next.running_slot = to_slot(best_idx_reg);
                    if (rem_dec == '0) begin
                        done_next[best_idx_reg] = 1'b1;
                        res_next.job_finished   = 1'b1;
                        res_next.turnaround     = to_out(tat);
                        res_next.job_waiting    = to_out(best_wait_reg);
                    end
                end else begin
                    res_next.idle = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot memory with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clock_reg   <= '0;
            loaded_reg  <= '0;
            done_reg    <= '0;
            iss_on_reg  <= 1'b0;
            chk_on_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            loaded_reg  <= loaded_next;
            done_reg    <= done_next;
            iss_on_reg  <= iss_on_next;
            chk_on_reg  <= chk_on_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and index registers.
    always_ff @(posedge aclk) begin
        iss_reg       <= iss_next;
        chk_idx_reg   <= chk_idx_next;
        best_idx_reg  <= best_idx_next;
        best_arr_reg  <= best_arr_next;
        best_rem_reg  <= best_rem_next;
        best_wait_reg <= best_wait_next;
        res_reg       <= res_next;
        m_item_reg    <= m_item_next;
    end

endmodule

FILE: rtl/srtf_chk.sv
`include "srtf_tick_scheduler_core_assert.svh"

module srtf_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input srtf_pkg::s_item_t s_item,
    input logic              m_valid,
    input logic              m_ready,
    input srtf_pkg::m_item_t m_item
);
    import srtf_pkg::*;

    logic s_seen;
    assign s_seen = s_valid && s_ready && (s_item.kind != KIND_TICK);

    // An idle tick runs nothing and finishes nothing.
    `SRTF_ASSERT_IMP(a_idle_quiet, aclk, aresetn, m_valid && m_item.idle,
        (m_item.running_slot == '0) && !m_item.job_finished)

    // Completion figures appear only with a finished job.
    `SRTF_ASSERT_IMP(a_fin_fields, aclk, aresetn, m_valid && !m_item.job_finished,
        (m_item.turnaround == '0) && (m_item.job_waiting == '0))

    // A stalled result holds.
    `SRTF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_item))

    // An accepted item that is not a tick holds off the input in the next cycle.
    `SRTF_ASSERT_NXT(a_nontick_next, aclk, aresetn, s_seen, !s_ready)

endmodule

bind srtf_tick_scheduler_core srtf_chk u_srtf_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

FILE: tb/tb.sv
module tb;
    import srtf_pkg::*;

    localparam int NSLOT = 16;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 1100;
    localparam logic [15:0] TIME_TOP = 16'hFFFF;

    // Shadow of the scheduler state and the queue of reports it still owes.
    class srtf_shadow;
        bit [15:0] job_arr[NSLOT];
        bit [15:0] job_left[NSLOT];
        bit [15:0] job_wait[NSLOT];
        bit        job_live[NSLOT];
        bit        job_over[NSLOT];
        bit [15:0] sim_now;
        m_item_t   due_reports[$];
        int        errors;
        int        checked;
        int        finished;
        int        idle_ticks;
        int        top_ticks;

        function void wipe();
            sim_now = '0;
            for (int s = 0; s < NSLOT; s++) begin
                job_arr[s]  = '0;
                job_left[s] = '0;
                job_wait[s] = '0;
                job_live[s] = 1'b0;
                job_over[s] = 1'b0;
            end
        endfunction

        function bit [15:0] sat_up(bit [15:0] v);
            return (v == TIME_TOP) ? v : v + 16'd1;
        endfunction

        function bit can_run(int s);
            return job_live[s] && !job_over[s] && job_arr[s] <= sim_now;
        endfunction

        // Work out the report for an accepted item and queue it.
        function void note_item(s_item_t it);
            m_item_t want;
            int      best;
            bit      found;
            want  = '0;
            best  = 0;
            found = 1'b0;
            case (it.kind)
                KIND_LOAD: begin
                    job_arr[it.slot]  = it.arrival_time;
                    job_left[it.slot] = it.burst_length;
                    job_wait[it.slot] = '0;
                    job_live[it.slot] = 1'b1;
                    job_over[it.slot] = (it.burst_length == 0);
                end
                KIND_TICK: begin
                    // Least remaining time wins, then earlier arrival, then lower slot.
                    for (int s = 0; s < NSLOT; s++) begin
                        if (can_run(s) && (!found || job_left[s] < job_left[best] ||
                                (job_left[s] == job_left[best] &&
                                 job_arr[s] < job_arr[best]))) begin
                            best  = s;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        want.idle = 1'b1;
                        idle_ticks++;
                    end else begin
                        for (int s = 0; s < NSLOT; s++) begin
                            if (s != best && can_run(s))
                                job_wait[s] = sat_up(job_wait[s]);
                        end
                        job_left[best]    = job_left[best] - 16'd1;
                        want.running_slot = best[3:0];
                    end
                    sim_now = sat_up(sim_now);
                    if (sim_now == TIME_TOP)
                        top_ticks++;
                    if (found && job_left[best] == 0) begin
                        job_over[best]    = 1'b1;
                        want.job_finished = 1'b1;
                        want.turnaround   = sim_now - job_arr[best];
                        want.job_waiting  = job_wait[best];
                        finished++;
                    end
                end
                KIND_CLEAR: begin
                    wipe();
                end
                default: begin
                end
            endcase
            want.current_time = sim_now;
            due_reports.push_back(want);
        endfunction

        function void field_err(string name, int unsigned want, int unsigned got);
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        endfunction

        // Compare one result item with the oldest queued report.
        function void check_report(m_item_t got);
            m_item_t want;
            if (due_reports.size() == 0) begin
                $error("result item with nothing expected: %p", got);
                errors++;
                return;
            end
            want = due_reports.pop_front();
            checked++;
            if (got.running_slot !== want.running_slot)
                field_err("running_slot", 32'(want.running_slot), 32'(got.running_slot));
            if (got.idle !== want.idle)
                field_err("idle", 32'(want.idle), 32'(got.idle));
            if (got.job_finished !== want.job_finished)
                field_err("job_finished", 32'(want.job_finished), 32'(got.job_finished));
            if (got.turnaround !== want.turnaround)
                field_err("turnaround", 32'(want.turnaround), 32'(got.turnaround));
            if (got.job_waiting !== want.job_waiting)
                field_err("job_waiting", 32'(want.job_waiting), 32'(got.job_waiting));
            if (got.current_time !== want.current_time)
                field_err("current_time", 32'(want.current_time), 32'(got.current_time));
        endfunction
    endclass

    logic    aclk;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_item_t s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_item_t m_item;

    srtf_shadow book;
    bit quiet;
    bit hold_request;
    int items_sent;
    int useful_sent;
    int tick_count;
    int hold_count;

    srtf_tick_scheduler_core u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic s_item_t make_item(logic [KIND_W-1:0] k);
        s_item_t it;
        it.kind         = k;
        it.slot         = 4'($urandom_range(0, NSLOT - 1));
        it.arrival_time = 16'($urandom);
        it.burst_length = 16'($urandom);
        return it;
    endfunction

    function automatic s_item_t job_item(int slot, int arr, int burst);
        s_item_t it;
        it.kind         = KIND_LOAD;
        it.slot         = slot[3:0];
        it.arrival_time = arr[15:0];
        it.burst_length = burst[15:0];
        return it;
    endfunction

    // A random job, mostly arriving soon and short.
    function automatic s_item_t random_job();
        int arr;
        int burst;
        int r;
        arr = int'(book.sim_now) + $urandom_range(0, 6);
        if (arr > 65535)
            arr = 65535;
        if ($urandom_range(0, 4) == 0)
            arr = $urandom_range(0, 65535);
        r = $urandom_range(0, 99);
        if (r < 70)
            burst = $urandom_range(1, 6);
        else if (r < 85)
            burst = $urandom_range(7, 40);
        else if (r < 90)
            burst = 0;
        else
            burst = $urandom_range(0, 65535);
        return job_item($urandom_range(0, NSLOT - 1), arr, burst);
    endfunction

    // Offer one item after an optional gap and wait for it to be taken.
    task automatic push_item(input s_item_t it);
        int n;
        n = quiet ? 0 : pick_gap();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        book.note_item(it);
        items_sent++;
        if (it.kind != KIND_SPARE)
            useful_sent++;
        if (it.kind == KIND_TICK)
            tick_count++;
    endtask

    // Stop offering and wait until every queued report has come back.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.due_reports.size() != 0);
    endtask

    // One scheduling episode: an optional clear, a few jobs, then ticks with late loads and noise mixed in.
    task automatic run_episode(input bit squeeze);
        int jobs;
        int budget;
        int ticks;
        int r;
        s_item_t it;
        quiet = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 1))
            push_item(make_item(KIND_CLEAR));
        if (squeeze)
            hold_request = 1'b1;
        jobs   = $urandom_range(1, 6);
        budget = 0;
        repeat (jobs) begin
            it = random_job();
            budget += (it.burst_length > 40) ? 40 : int'(it.burst_length);
            push_item(it);
        end
        ticks = budget + $urandom_range(0, 4);
        if (ticks > 60)
            ticks = 60;
        repeat (ticks) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                push_item(random_job());
            else if (r < 11)
                push_item(make_item(KIND_SPARE));
            else
                push_item(make_item(KIND_TICK));
        end
    endtask

    // Result side: check each item, stall at random, and honor long hold-off requests.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                book.check_report(m_item);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
                hold_count++;
            end else if (m_valid && m_ready && !quiet && stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    initial begin
        int dry;
        dry = 0;
        wait (aresetn);
        while (dry < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                dry = 0;
            else
                dry++;
        end
        $display("No item moved for %0d cycles.", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int episodes;
        int random_goal;
        book = new;
        book.wipe();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty tick, unused kind, zero burst, extreme fields, ties, reload, clear.
        push_item(make_item(KIND_TICK));
        push_item(make_item(KIND_SPARE));
        push_item(job_item(0, 0, 0));
        push_item(make_item(KIND_TICK));
        push_item(job_item(15, 65535, 65535));
        push_item(job_item(4, 3, 2));
        push_item(job_item(9, 3, 2));
        push_item(job_item(2, 4, 2));
        push_item(job_item(12, 2, 1));
        repeat (6) push_item(make_item(KIND_TICK));
        push_item(job_item(2, 0, 1));
        push_item(make_item(KIND_TICK));
        push_item(make_item(KIND_TICK));
        push_item(make_item(KIND_CLEAR));
        push_item(make_item(KIND_TICK));
        push_item(job_item(0, 0, 1));
        push_item(make_item(KIND_TICK));
        drain();

        // Random episodes, two of them under a long receiver hold-off.
        episodes    = 0;
        random_goal = useful_sent + RANDOM_ITEMS;
        while (useful_sent < random_goal) begin
            run_episode(episodes == 3 || episodes == 25);
            episodes++;
        end
        drain();
        repeat (60) @(posedge aclk);

        $display("Sent %0d items (%0d ticks, %0d episodes); checked %0d results.",
                 items_sent, tick_count, episodes, book.checked);
        $display("Jobs finished: %0d, idle ticks: %0d, ticks at the time ceiling: %0d, holds: %0d.",
                 book.finished, book.idle_ticks, book.top_ticks, hold_count);
        if (book.errors == 0 && book.due_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
